// ===== rtl/i2c_master_bit_engine_unit_assert.svh =====
// Assertion macros used by the checker file of the I2C master bit engine
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define I2CMBE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cmbe check failed");

// Check that cons holds in the cycle after ante
`define I2CMBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cmbe check failed");

`endif

// ===== rtl/i2cmbe_pkg.sv =====
// Package of types and command codes for the I2C master bit engine
package i2cmbe_pkg;

    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_STOP     = 3'd1;
    localparam logic [2:0] CMD_WRITE    = 3'd2;
    localparam logic [2:0] CMD_READ     = 3'd3;
    localparam logic [2:0] CMD_WAIT_ACK = 3'd4;
    localparam logic [2:0] CMD_ACK      = 3'd5;
    localparam logic [2:0] CMD_NACK     = 3'd6;
    localparam logic [2:0] CMD_UNUSED   = 3'd7;

    // Last bit index of a byte and last phase of each bit kind
    localparam logic [2:0] LAST_BIT         = 3'd7;
    localparam logic [1:0] WRITE_LAST_PHASE = 2'd2;
    localparam logic [1:0] READ_LAST_PHASE  = 2'd1;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic [7:0] line_samples;
    } t_in_item;

    typedef struct packed {
        logic       clock_level;
        logic       data_level;
        logic       wait_after;
        logic [7:0] rx_byte;
        logic       no_ack;
        logic       last;
    } t_out_item;

    // Queued command and head-of-queue status
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic [7:0] line_samples;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/i2cmbe_front.sv =====
// Front end: accepts commands, drops unused codes, pushes jobs into the queue
module i2cmbe_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cmbe_pkg::t_in_item  i_in_item,
    input  i2cmbe_pkg::t_q_status i_q_status,
    output logic                  o_push,
    output i2cmbe_pkg::t_job      o_job
);

    logic r_ready;

    // Hold ready low during reset, then follow queue space
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign o_in_ready = r_ready && !i_q_status.full;

    // Push only commands that produce line segments
    assign o_push = i_in_valid && o_in_ready
                    && (i_in_item.command != i2cmbe_pkg::CMD_UNUSED);

    assign o_job.command      = i_in_item.command;
    assign o_job.tx_byte      = i_in_item.tx_byte;
    assign o_job.line_samples = i_in_item.line_samples;

endmodule

// ===== rtl/i2cmbe_queue.sv =====
// Two-entry job queue between the front end and the segment sequencer
module i2cmbe_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  i2cmbe_pkg::t_job      i_job,
    input  logic                  i_pop,
    output i2cmbe_pkg::t_q_status o_status,
    output i2cmbe_pkg::t_job      o_head
);

    i2cmbe_pkg::t_job r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_pop;

    assign do_pop = i_pop && (r_count != 2'd0);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the job payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign o_head         = r_slot[r_rd_ptr];

endmodule

// ===== rtl/i2cmbe_back.sv =====
// Back end: steps through the line segments of the head job, one per cycle while the output is not stalled
module i2cmbe_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  i2cmbe_pkg::t_q_status i_q_status,
    input  i2cmbe_pkg::t_job      i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cmbe_pkg::t_out_item o_out_item
);

    logic                  r_clk_line;
    logic                  r_dat_line;
    logic [2:0]            r_bit;
    logic [1:0]            r_phase;
    logic                  r_out_valid;
    i2cmbe_pkg::t_out_item r_out;

    logic                  step;
    i2cmbe_pkg::t_out_item seg;
    logic                  tx_bit;

    assign step   = !i_q_status.empty && (!r_out_valid || i_out_ready);
    assign tx_bit = i_head.tx_byte[~r_bit];

    // Build the current segment from the job, the counters and the line state
    always_comb begin
        seg.clock_level = r_clk_line;
        seg.data_level  = r_dat_line;
        seg.wait_after  = 1'b1;
        seg.rx_byte     = 8'd0;
        seg.no_ack      = 1'b0;
        seg.last        = 1'b0;
        case (i_head.command)
            i2cmbe_pkg::CMD_START: begin
                case (r_phase)
                    2'd0: begin
                        seg.clock_level = 1'b1;
                        seg.data_level  = 1'b1;
                    end
                    2'd1: begin
                        seg.clock_level = 1'b1;
                        seg.data_level  = 1'b0;
                    end
                    default: begin
                        seg.clock_level = 1'b0;
                        seg.data_level  = 1'b0;
                        seg.last        = 1'b1;
                    end
                endcase
            end
            i2cmbe_pkg::CMD_STOP: begin
                seg.clock_level = 1'b1;
                if (r_phase == 2'd0) begin
                    seg.data_level = 1'b0;
                end else begin
                    seg.data_level = 1'b1;
                    seg.wait_after = 1'b0;
                    seg.last       = 1'b1;
                end
            end
            i2cmbe_pkg::CMD_WRITE: begin
                case (r_phase)
                    2'd0: seg.data_level = tx_bit;
                    2'd1: seg.clock_level = 1'b1;
                    default: begin
                        seg.clock_level = 1'b0;
                        if (r_bit == i2cmbe_pkg::LAST_BIT) begin
                            seg.data_level = 1'b1;
                            seg.last       = 1'b1;
                        end
                    end
                endcase
            end
            i2cmbe_pkg::CMD_READ: begin
                if (r_phase == 2'd0) begin
                    seg.clock_level = 1'b1;
                end else begin
                    seg.clock_level = 1'b0;
                    if (r_bit == i2cmbe_pkg::LAST_BIT) begin
                        seg.rx_byte = i_head.line_samples;
                        seg.last    = 1'b1;
                    end
                end
            end
            i2cmbe_pkg::CMD_WAIT_ACK, i2cmbe_pkg::CMD_NACK: begin
                case (r_phase)
                    2'd0: seg.data_level = 1'b1;
                    2'd1: seg.clock_level = 1'b1;
                    default: begin
                        seg.clock_level = 1'b0;
                        seg.last        = 1'b1;
                        if (i_head.command == i2cmbe_pkg::CMD_WAIT_ACK) begin
                            seg.no_ack = i_head.line_samples[0];
                        end
                    end
                endcase
            end
            i2cmbe_pkg::CMD_ACK: begin
                case (r_phase)
                    2'd0: seg.data_level = 1'b0;
                    2'd1: seg.clock_level = 1'b1;
                    2'd2: seg.clock_level = 1'b0;
                    default: begin
                        seg.data_level = 1'b1;
                        seg.wait_after = 1'b0;
                        seg.last       = 1'b1;
                    end
                endcase
            end
            default: begin
                // Unused codes never reach the queue; retire at once
                seg.last = 1'b1;
            end
        endcase
    end

    assign o_pop = step && seg.last;

    // Advance the segment counters and the line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_line  <= 1'b1;
            r_dat_line  <= 1'b1;
            r_bit       <= 3'd0;
            r_phase     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_clk_line  <= seg.clock_level;
                r_dat_line  <= seg.data_level;
                r_out_valid <= 1'b1;
                if (seg.last) begin
                    r_bit   <= 3'd0;
                    r_phase <= 2'd0;
                end else if ((i_head.command == i2cmbe_pkg::CMD_WRITE
                              && r_phase == i2cmbe_pkg::WRITE_LAST_PHASE)
                             || (i2cmbe_pkg::CMD_READ == i_head.command
                              && r_phase == i2cmbe_pkg::READ_LAST_PHASE)) begin
                    r_bit   <= r_bit + 3'd1;
                    r_phase <= 2'd0;
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Register the outgoing segment
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= seg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/i2c_master_bit_engine_unit.sv =====
// A command taken in is written into the job queue; the segment sequencer then registers its first segment.
// Throughput: one segment per cycle while the output is not stalled; a command makes write 24, read 16,
// start 3, stop 2, wait ack 3, send ack 4, send nack 3 segments, set by the segment sequencer.
// Code 7 is taken in and produces nothing. Reset: SCL and SDA released high,
// queue and output register emptied, input ready in the cycle after reset ends.
module i2c_master_bit_engine_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cmbe_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cmbe_pkg::t_out_item o_out_item
);

    i2cmbe_pkg::t_q_status q_status;
    i2cmbe_pkg::t_job      push_job;
    i2cmbe_pkg::t_job      head_job;
    logic                  push;
    logic                  pop;

    i2cmbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    i2cmbe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (head_job)
    );

    i2cmbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_head      (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/i2cmbe_checker.sv =====
// Port-level checker for the I2C master bit engine and its bind
`include "i2c_master_bit_engine_unit_assert.svh"

module i2cmbe_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input i2cmbe_pkg::t_out_item o_out_item
);

    // Hold a stalled segment
    `I2CMBE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // Flag a missing ack only on the final segment
    `I2CMBE_ASSERT_SAME(a_nack_last, i_clk, i_rst_n, o_out_valid && o_out_item.no_ack, o_out_item.last)

    // Show a received byte only on the final segment
    `I2CMBE_ASSERT_SAME(a_rx_last, i_clk, i_rst_n, o_out_valid && (o_out_item.rx_byte != 8'd0), o_out_item.last)

    // Skip the half-bit wait only at the end of a stop or an ack, with SDA released
    `I2CMBE_ASSERT_SAME(a_nowait_end, i_clk, i_rst_n, o_out_valid && !o_out_item.wait_after, o_out_item.last && o_out_item.data_level)

endmodule

bind i2c_master_bit_engine_unit i2cmbe_checker u_i2cmbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
